// ===== hdl/matrix4_inverse_adjugate_top_assert.svh =====
// Assertion macros for the matrix inverse block.
`ifndef MATRIX4_INVERSE_ADJUGATE_TOP_ASSERT_SVH
`define MATRIX4_INVERSE_ADJUGATE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define M4I_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define M4I_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/m4i_pkg.sv =====
`default_nettype none
package m4i_pkg;

  localparam int unsigned DefElemWidth = 32;
  localparam int unsigned DefFracBits  = 16;

  // Address of element (i, j) of the 3x3 submatrix that drops row k[3:2]
  // and column k[1:0].
  function automatic logic [3:0] elem_addr(input logic [3:0] k, input logic [1:0] i,
                                           input logic [1:0] j);
    logic [1:0] row;
    logic [1:0] col;
    row = (i < k[3:2]) ? i : i + 2'd1;
    col = (j < k[1:0]) ? j : j + 2'd1;
    return {row, col};
  endfunction

endpackage
`default_nettype wire

// ===== hdl/m4i_ram.sv =====
`default_nettype none
module m4i_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== hdl/m4i_fmul.sv =====
`default_nettype none
module m4i_fmul import m4i_pkg::*; #(
  parameter int unsigned ElemWidth = DefElemWidth,
  parameter int unsigned FracBits  = DefFracBits
) (
  input  wire logic signed [ElemWidth-1:0] a_i,
  input  wire logic signed [ElemWidth-1:0] b_i,
  output logic signed      [ElemWidth-1:0] p_o,
  output logic                             clip_o
);

  localparam int unsigned PW = 2 * ElemWidth;

  logic signed [PW-1:0] full;
  logic signed [PW-1:0] shifted;
  logic                 fits;

  // The arithmetic shift floors, which matches rounding toward minus infinity.
  assign full    = a_i * b_i;
  assign shifted = full >>> FracBits;
  assign fits    = (&shifted[PW-1:ElemWidth-1]) || !(|shifted[PW-1:ElemWidth-1]);
  assign clip_o  = !fits;

  always_comb begin
    if (fits) begin
      p_o = shifted[ElemWidth-1:0];
    end else if (shifted[PW-1]) begin
      p_o = {1'b1, {(ElemWidth-1){1'b0}}};
    end else begin
      p_o = {1'b0, {(ElemWidth-1){1'b1}}};
    end
  end

endmodule
`default_nettype wire

// ===== hdl/matrix4_inverse_adjugate_top.sv =====
`default_nettype none
// Inverts a 4x4 signed fixed-point matrix by the adjugate. Sixteen elements
// enter one per item in row-major order; the block then stops accepting and
// works on one shared multiplier and a bit-serial divider, and finally sends
// sixteen result items in row-major order, the last one marked by tlast.
// A matrix is loaded, then the sixteen cofactors are formed (nine
// multiply-accumulate steps of read, multiply and accumulate states, plus
// a sign step, for each of sixteen), then the determinant, then the
// reciprocal (skipped when singular), and each result is scaled and sent,
// held until taken. tuser[0] flags a singular matrix, whose results are
// the unscaled adjugate; tuser[1] flags an element that was clamped
// somewhere along its computation.
module matrix4_inverse_adjugate_top import m4i_pkg::*; #(
  parameter int unsigned ELEM_WIDTH = DefElemWidth,
  parameter int unsigned FRAC_BITS  = DefFracBits
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   s_axis_tvalid,
  output logic                                        s_axis_tready,
  // element
  input  wire logic [((ELEM_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
  output logic                                        m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  // inv_value, out_row, out_col, zero fill
  output logic [((ELEM_WIDTH+4+7)/8)*8-1:0]           m_axis_tdata,
  // singular, saturated
  output logic [1:0]                                  m_axis_tuser,
  output logic                                        m_axis_tlast
);

  localparam int unsigned W   = ELEM_WIDTH;
  localparam int unsigned QW  = 2 * FRAC_BITS + 1;
  localparam int unsigned CW  = ((QW > W) ? QW : W) + 1;
  localparam int unsigned DCW = $clog2(QW);
  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_ACC  = 4'd3;
  localparam logic [3:0] S_NEG  = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_RCP  = 4'd6;
  localparam logic [3:0] S_OMUL = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_SUB  = 2'd1;
  localparam logic [1:0] OP_ADD  = 2'd2;

  logic [3:0]          st_q, st_d;
  logic [3:0]          load_cnt_q;
  logic [3:0]          k_q;
  logic [3:0]          step_q;
  logic                det_ph_q;
  logic signed [W-1:0] acc_q, q0_q, q1_q, q2_q, prod_q, det_q, recip_q, oval_q;
  logic                pclip_q, clip_q, dclip_q, sing_q, osat_q;
  logic signed [W-1:0] cof_q [16];
  logic [15:0]         cclip_q;
  logic [W-1:0]        rem_q;
  logic [QW-1:0]       quo_q;
  logic [DCW-1:0]      dcnt_q;

  logic [1:0]          ai, aj, bi, bj, op;
  logic [3:0]          raddr_a, raddr_b, cof_idx;
  logic [W-1:0]        rd_a, rd_b;
  logic signed [W-1:0] mul_a, mul_b, mul_p, cof_rd, acc_new, neg_val, recip_new;
  logic                mul_clip, acc_clip, neg_clip, recip_clip, in_acc;
  logic signed [W:0]   sum;
  logic [W-1:0]        det_mag;
  logic [W:0]          trial;
  logic [CW-1:0]       qx;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Operand schedule of one 3x3 minor: three 2x2 minors, then the row.
  always_comb begin
    ai = 2'd0; aj = 2'd0; bi = 2'd0; bj = 2'd0; op = OP_LOAD;
    unique case (step_q)
      4'd0: begin ai = 2'd1; aj = 2'd1; bi = 2'd2; bj = 2'd2; op = OP_LOAD; end
      4'd1: begin ai = 2'd1; aj = 2'd2; bi = 2'd2; bj = 2'd1; op = OP_SUB; end
      4'd2: begin ai = 2'd1; aj = 2'd0; bi = 2'd2; bj = 2'd2; op = OP_LOAD; end
      4'd3: begin ai = 2'd1; aj = 2'd2; bi = 2'd2; bj = 2'd0; op = OP_SUB; end
      4'd4: begin ai = 2'd1; aj = 2'd0; bi = 2'd2; bj = 2'd1; op = OP_LOAD; end
      4'd5: begin ai = 2'd1; aj = 2'd1; bi = 2'd2; bj = 2'd0; op = OP_SUB; end
      4'd6: begin ai = 2'd0; aj = 2'd0; op = OP_LOAD; end
      4'd7: begin ai = 2'd0; aj = 2'd1; op = OP_SUB; end
      4'd8: begin ai = 2'd0; aj = 2'd2; op = OP_ADD; end
      default: begin ai = 2'd0; aj = 2'd0; op = OP_LOAD; end
    endcase
    if (det_ph_q) begin
      op = (step_q == 4'd0) ? OP_LOAD : OP_ADD;
    end
  end

  assign raddr_a = det_ph_q ? step_q : elem_addr(k_q, ai, aj);
  assign raddr_b = elem_addr(k_q, bi, bj);

  m4i_ram #(.Width(W), .Depth(16)) u_ram_a (
    .clk_i, .we_i(in_acc), .waddr_i(load_cnt_q), .wdata_i(s_axis_tdata[W-1:0]),
    .raddr_i(raddr_a), .rdata_o(rd_a)
  );

  m4i_ram #(.Width(W), .Depth(16)) u_ram_b (
    .clk_i, .we_i(in_acc), .waddr_i(load_cnt_q), .wdata_i(s_axis_tdata[W-1:0]),
    .raddr_i(raddr_b), .rdata_o(rd_b)
  );

  // Adjugate element (row i, col j) is cofactor (j, i).
  assign cof_idx = (st_q == S_OMUL) ? {k_q[1:0], k_q[3:2]} : step_q;
  assign cof_rd  = cof_q[cof_idx];

  always_comb begin
    mul_a = rd_a;
    mul_b = rd_b;
    if (st_q == S_OMUL) begin
      mul_a = cof_rd;
      mul_b = recip_q;
    end else if (det_ph_q) begin
      mul_b = cof_rd;
    end else if (step_q == 4'd6) begin
      mul_b = q0_q;
    end else if (step_q == 4'd7) begin
      mul_b = q1_q;
    end else if (step_q == 4'd8) begin
      mul_b = q2_q;
    end
  end

  m4i_fmul #(.ElemWidth(W), .FracBits(FRAC_BITS)) u_fmul (
    .a_i(mul_a), .b_i(mul_b), .p_o(mul_p), .clip_o(mul_clip)
  );

  always_comb begin
    case (op)
      OP_SUB:  sum = {acc_q[W-1], acc_q} - {prod_q[W-1], prod_q};
      OP_ADD:  sum = {acc_q[W-1], acc_q} + {prod_q[W-1], prod_q};
      default: sum = {prod_q[W-1], prod_q};
    endcase
    acc_clip = sum[W] != sum[W-1];
    acc_new  = acc_clip ? (sum[W] ? VMIN : VMAX) : sum[W-1:0];
    neg_clip = (acc_q == VMIN);
    neg_val  = neg_clip ? VMAX : -acc_q;
  end

  assign det_mag = det_q[W-1] ? -det_q : det_q;
  assign trial   = {rem_q, (dcnt_q == DCW'(QW - 1))};
  assign qx      = CW'(quo_q);

  always_comb begin
    if (!det_q[W-1]) begin
      recip_clip = qx > CW'(VMAX);
      recip_new  = recip_clip ? VMAX : qx[W-1:0];
    end else begin
      recip_clip = qx > (CW'(VMAX) + CW'(1));
      recip_new  = recip_clip ? VMIN : -qx[W-1:0];
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_LOAD: if (in_acc && load_cnt_q == 4'd15) st_d = S_RD;
      S_RD:   st_d = S_MUL;
      S_MUL:  st_d = S_ACC;
      S_ACC: begin
        if (!det_ph_q) begin
          st_d = (step_q == 4'd8) ? S_NEG : S_RD;
        end else if (step_q != 4'd3) begin
          st_d = S_RD;
        end else begin
          st_d = (acc_new == '0) ? S_OMUL : S_DIV;
        end
      end
      S_NEG:  st_d = S_RD;
      S_DIV:  if (dcnt_q == '0) st_d = S_RCP;
      S_RCP:  st_d = S_OMUL;
      S_OMUL: st_d = S_OUT;
      S_OUT:  if (m_axis_tready) st_d = (k_q == 4'd15) ? S_LOAD : S_OMUL;
      default: st_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_LOAD;
      load_cnt_q <= '0;
      k_q        <= '0;
      step_q     <= '0;
      det_ph_q   <= 1'b0;
    end else begin
      st_q <= st_d;
      if (in_acc) load_cnt_q <= load_cnt_q + 4'd1;
      if (st_q == S_ACC) begin
        if (det_ph_q && step_q == 4'd3) begin
          k_q    <= '0;
          step_q <= '0;
        end else if (!(!det_ph_q && step_q == 4'd8)) begin
          step_q <= step_q + 4'd1;
        end
      end
      if (st_q == S_NEG) begin
        step_q <= '0;
        k_q    <= k_q + 4'd1;
        if (k_q == 4'd15) det_ph_q <= 1'b1;
      end
      if (st_q == S_OUT && m_axis_tready) begin
        k_q <= k_q + 4'd1;
        if (k_q == 4'd15) det_ph_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_LOAD) clip_q <= 1'b0;
    if (st_q == S_MUL) begin
      prod_q  <= mul_p;
      pclip_q <= mul_clip;
    end
    if (st_q == S_ACC) begin
      acc_q  <= acc_new;
      clip_q <= clip_q | pclip_q | acc_clip;
      if (!det_ph_q && step_q == 4'd1) q0_q <= acc_new;
      if (!det_ph_q && step_q == 4'd3) q1_q <= acc_new;
      if (!det_ph_q && step_q == 4'd5) q2_q <= acc_new;
      if (det_ph_q && step_q == 4'd3) begin
        det_q   <= acc_new;
        dclip_q <= clip_q | pclip_q | acc_clip;
        sing_q  <= (acc_new == '0);
        rem_q   <= '0;
        quo_q   <= '0;
        dcnt_q  <= DCW'(QW - 1);
      end
    end
    if (st_q == S_NEG) begin
      cof_q[k_q]   <= ((k_q[2] ^ k_q[0]) != 1'b0) ? neg_val : acc_q;
      cclip_q[k_q] <= clip_q | (((k_q[2] ^ k_q[0]) != 1'b0) && neg_clip);
      clip_q       <= 1'b0;
    end
    if (st_q == S_DIV) begin
      if (trial >= {1'b0, det_mag}) begin
        rem_q <= W'(trial - {1'b0, det_mag});
        quo_q <= {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_q <= trial[W-1:0];
        quo_q <= {quo_q[QW-2:0], 1'b0};
      end
      dcnt_q <= dcnt_q - DCW'(1);
    end
    if (st_q == S_RCP) begin
      recip_q <= recip_new;
      dclip_q <= dclip_q | recip_clip;
    end
    if (st_q == S_OMUL) begin
      oval_q <= sing_q ? cof_rd : mul_p;
      osat_q <= sing_q ? cclip_q[cof_idx] : (cclip_q[cof_idx] | dclip_q | mul_clip);
    end
  end

  assign s_axis_tready = (st_q == S_LOAD);
  assign m_axis_tvalid = (st_q == S_OUT);
  assign m_axis_tlast  = (k_q == 4'd15);
  assign m_axis_tuser  = {osat_q, sing_q};

  always_comb begin
    m_axis_tdata            = '0;
    m_axis_tdata[W-1:0]     = oval_q;
    m_axis_tdata[W+1:W]     = k_q[3:2];
    m_axis_tdata[W+3:W+2]   = k_q[1:0];
  end

`include "matrix4_inverse_adjugate_top_assert.svh"

  `M4I_ASSERT_IMP(a_no_overlap, s_axis_tready, !m_axis_tvalid, "load and output overlap")
  `M4I_ASSERT_IMP(a_sing_det, m_axis_tvalid && m_axis_tuser[0], det_q == '0, "singular flag with nonzero determinant")
  `M4I_ASSERT_NXT(a_last_wrap, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready && load_cnt_q == '0, "no return to loading after last item")

endmodule
`default_nettype wire
